// ===== sv/dhc_pkg.sv =====
package dhc_pkg;

    typedef enum logic [1:0] {
        ZONE_NONE  = 2'd0,
        ZONE_NEAR  = 2'd1,
        ZONE_RANGE = 2'd2,
        ZONE_FAR   = 2'd3
    } zone_t;

    localparam int NEAR_MM = 700;
    localparam int FAR_MM  = 4200;

    localparam int DIFF_W  = 12;
    localparam int HUE_W   = 16;
    localparam int RECIP_W = 29;
    localparam int PROD_W  = DIFF_W + RECIP_W;
    localparam int SECT_W  = 3;
    localparam int X_W     = HUE_W + SECT_W;
    localparam int SF_W    = 31;
    localparam int VN_W    = 4;
    localparam int KV_W    = 12;
    localparam int KC_W    = 27;
    localparam int P_W     = KV_W + SF_W;
    localparam int ACC_W   = P_W + 1;
    localparam int CH_W    = 8;

    // ceil(2^40 / 3500); (diff * HUE_RECIP) >> 24 equals floor(diff * 2^16 / 3500)
    localparam logic [RECIP_W-1:0] HUE_RECIP = 29'd314146180;
    localparam int                 HUE_SHIFT = 24;

    localparam logic [HUE_W-1:0] SAT_Q16  = 16'd29491;
    localparam logic [HUE_W-1:0] SAT_COMP = 16'd36045;
    localparam logic [VN_W-1:0]  VN_BASE  = 4'd12;

    localparam logic [SECT_W-1:0] SECT_0 = 3'd0;
    localparam logic [SECT_W-1:0] SECT_1 = 3'd1;
    localparam logic [SECT_W-1:0] SECT_2 = 3'd2;
    localparam logic [SECT_W-1:0] SECT_3 = 3'd3;
    localparam logic [SECT_W-1:0] SECT_4 = 3'd4;

    localparam logic [CH_W-1:0] CH_MAX  = 8'd255;
    localparam logic [CH_W-1:0] CH_ZERO = 8'd0;

    typedef struct packed {
        zone_t            zone;
        logic [VN_W-1:0]  vn;
    } dhc_ctl_t;

endpackage

// ===== sv/dhc_classify.sv =====
module dhc_classify
    import dhc_pkg::*;
#(
    parameter int DEPTH_BITS = 13
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DEPTH_BITS-1:0] in_depth,
    output logic                  out_valid,
    input  logic                  out_ready,
    output dhc_ctl_t              out_ctl,
    output logic [DIFF_W-1:0]     out_diff
);

    localparam logic [DEPTH_BITS-1:0] NEAR_D = DEPTH_BITS'(NEAR_MM);
    localparam logic [DEPTH_BITS-1:0] FAR_D  = DEPTH_BITS'(FAR_MM);

    logic                  valid_reg;
    dhc_ctl_t              ctl_reg;
    dhc_ctl_t              ctl_next;
    logic [DIFF_W-1:0]     diff_reg;
    logic [DIFF_W-1:0]     diff_next;
    logic [DEPTH_BITS-1:0] delta;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        delta = in_depth - NEAR_D;
        diff_next = delta[DIFF_W-1:0];
        ctl_next.vn = VN_BASE - {1'b0, in_depth[10:8]};
        priority if (in_depth == '0) begin
            ctl_next.zone = ZONE_NONE;
        end else if (in_depth < NEAR_D) begin
            ctl_next.zone = ZONE_NEAR;
        end else if (in_depth > FAR_D) begin
            ctl_next.zone = ZONE_FAR;
        end else begin
            ctl_next.zone = ZONE_RANGE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ctl_reg  <= ctl_next;
            diff_reg <= diff_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_diff  = diff_reg;

endmodule

// ===== sv/dhc_hue.sv =====
module dhc_hue
    import dhc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  dhc_ctl_t          in_ctl,
    input  logic [DIFF_W-1:0] in_diff,
    output logic              out_valid,
    input  logic              out_ready,
    output dhc_ctl_t          out_ctl,
    output logic [SECT_W-1:0] out_sector,
    output logic [SF_W-1:0]   out_sf
);

    logic              v2_reg;
    dhc_ctl_t          ctl2_reg;
    logic [HUE_W-1:0]  hq2_reg;
    logic [HUE_W-1:0]  hq2_next;
    logic [PROD_W-1:0] prod;
    logic              rdy2;

    logic              v3_reg;
    dhc_ctl_t          ctl3_reg;
    logic [SECT_W-1:0] sector3_reg;
    logic [SECT_W-1:0] sector3_next;
    logic [SF_W-1:0]   sf3_reg;
    logic [SF_W-1:0]   sf3_next;
    logic [X_W-1:0]    x6;
    logic              rdy3;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = rdy2;

    // drop the carry so the top of the span wraps to hue zero
    always_comb begin
        prod     = PROD_W'(in_diff) * PROD_W'(HUE_RECIP);
        hq2_next = prod[HUE_SHIFT +: HUE_W];
    end

    always_comb begin
        x6           = (X_W'(hq2_reg) << 2) + (X_W'(hq2_reg) << 1);
        sector3_next = x6[X_W-1:HUE_W];
        sf3_next     = SF_W'(x6[HUE_W-1:0]) * SF_W'(SAT_Q16);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy2) begin
                v2_reg <= in_valid;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && in_valid) begin
            ctl2_reg <= in_ctl;
            hq2_reg  <= hq2_next;
        end
        if (rdy3 && v2_reg) begin
            ctl3_reg    <= ctl2_reg;
            sector3_reg <= sector3_next;
            sf3_reg     <= sf3_next;
        end
    end

    assign out_valid  = v3_reg;
    assign out_ctl    = ctl3_reg;
    assign out_sector = sector3_reg;
    assign out_sf     = sf3_reg;

endmodule

// ===== sv/dhc_shade.sv =====
module dhc_shade
    import dhc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  dhc_ctl_t          in_ctl,
    input  logic [SECT_W-1:0] in_sector,
    input  logic [SF_W-1:0]   in_sf,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CH_W-1:0]   out_red,
    output logic [CH_W-1:0]   out_green,
    output logic [CH_W-1:0]   out_blue,
    output logic [1:0]        out_zone
);

    logic              v4_reg;
    zone_t             zone4_reg;
    logic [SECT_W-1:0] sector4_reg;
    logic [KV_W-1:0]   kv4_reg;
    logic [KV_W-1:0]   kv4_next;
    logic [KC_W-1:0]   kc4_reg;
    logic [KC_W-1:0]   kc4_next;
    logic [P_W-1:0]    p4_reg;
    logic [P_W-1:0]    p4_next;
    logic              rdy4;

    logic              v5_reg;
    zone_t             zone5_reg;
    logic [CH_W-1:0]   red_reg;
    logic [CH_W-1:0]   red_next;
    logic [CH_W-1:0]   green_reg;
    logic [CH_W-1:0]   green_next;
    logic [CH_W-1:0]   blue_reg;
    logic [CH_W-1:0]   blue_next;
    logic              rdy5;

    logic [ACC_W-1:0]  acc2;
    logic [ACC_W-1:0]  acc3;
    logic [CH_W-1:0]   cv;
    logic [CH_W-1:0]   c1;
    logic [CH_W-1:0]   c2;
    logic [CH_W-1:0]   c3;

    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign in_ready = rdy4;

    // 255 * vn, then its products with 1 - S and with S * f
    always_comb begin
        kv4_next = {in_ctl.vn, 8'b0} - KV_W'(in_ctl.vn);
        kc4_next = KC_W'(kv4_next) * KC_W'(SAT_COMP);
        p4_next  = P_W'(kv4_next) * P_W'(in_sf);
    end

    always_comb begin
        acc2 = {kv4_reg, 32'b0} - {1'b0, p4_reg};
        acc3 = {1'b0, kc4_reg, 16'b0} + {1'b0, p4_reg};
        cv   = kv4_reg[KV_W-1:4];
        c1   = {1'b0, kc4_reg[KC_W-1:20]};
        c2   = acc2[ACC_W-1 -: CH_W];
        c3   = acc3[ACC_W-1 -: CH_W];
    end

    always_comb begin
        unique case (zone4_reg)
            ZONE_NONE: begin
                red_next   = CH_ZERO;
                green_next = CH_ZERO;
                blue_next  = CH_ZERO;
            end
            ZONE_NEAR: begin
                red_next   = CH_MAX;
                green_next = CH_MAX;
                blue_next  = CH_ZERO;
            end
            ZONE_FAR: begin
                red_next   = CH_MAX;
                green_next = CH_MAX;
                blue_next  = CH_MAX;
            end
            ZONE_RANGE: begin
                unique case (sector4_reg)
                    SECT_0: begin
                        red_next = cv; green_next = c3; blue_next = c1;
                    end
                    SECT_1: begin
                        red_next = c2; green_next = cv; blue_next = c1;
                    end
                    SECT_2: begin
                        red_next = c1; green_next = cv; blue_next = c3;
                    end
                    SECT_3: begin
                        red_next = c1; green_next = c2; blue_next = cv;
                    end
                    SECT_4: begin
                        red_next = c3; green_next = c1; blue_next = cv;
                    end
                    default: begin
                        red_next = cv; green_next = c1; blue_next = c2;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy4) begin
                v4_reg <= in_valid;
            end
            if (rdy5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && in_valid) begin
            zone4_reg   <= in_ctl.zone;
            sector4_reg <= in_sector;
            kv4_reg     <= kv4_next;
            kc4_reg     <= kc4_next;
            p4_reg      <= p4_next;
        end
        if (rdy5 && v4_reg) begin
            zone5_reg <= zone4_reg;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;
    assign out_zone  = zone5_reg;

endmodule

// ===== sv/depth_to_hsv_color.sv =====
// An accepted request passes through the five stages in order to m_valid.
// Throughput: one request per cycle unless m_ready stalls; each stage holds
// one request and moves on when the stage after it is empty or advancing.
// Reset: aresetn, synchronous and active low, empties every stage; payload
// registers are not reset.
module depth_to_hsv_color
    import dhc_pkg::*;
#(
    parameter int DEPTH_BITS = 13
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DEPTH_BITS-1:0] s_depth_mm,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CH_W-1:0]       m_red,
    output logic [CH_W-1:0]       m_green,
    output logic [CH_W-1:0]       m_blue,
    output logic [1:0]            m_zone
);

    logic              v1;
    logic              r1;
    dhc_ctl_t          ctl1;
    logic [DIFF_W-1:0] diff1;

    logic              v3;
    logic              r3;
    dhc_ctl_t          ctl3;
    logic [SECT_W-1:0] sector3;
    logic [SF_W-1:0]   sf3;

    dhc_classify #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_depth  (s_depth_mm),
        .out_valid (v1),
        .out_ready (r1),
        .out_ctl   (ctl1),
        .out_diff  (diff1)
    );

    dhc_hue u_hue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (v1),
        .in_ready   (r1),
        .in_ctl     (ctl1),
        .in_diff    (diff1),
        .out_valid  (v3),
        .out_ready  (r3),
        .out_ctl    (ctl3),
        .out_sector (sector3),
        .out_sf     (sf3)
    );

    dhc_shade u_shade (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v3),
        .in_ready  (r3),
        .in_ctl    (ctl3),
        .in_sector (sector3),
        .in_sf     (sf3),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_red   (m_red),
        .out_green (m_green),
        .out_blue  (m_blue),
        .out_zone  (m_zone)
    );

`ifndef ASSERT_OFF
    a_none_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_zone == ZONE_NONE) |->
            (m_red == CH_ZERO) && (m_green == CH_ZERO) && (m_blue == CH_ZERO))
        else $error("no-reading result is not black");

    a_near_yellow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_zone == ZONE_NEAR) |->
            (m_red == CH_MAX) && (m_green == CH_MAX) && (m_blue == CH_ZERO))
        else $error("near result is not yellow");

    a_far_white: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_zone == ZONE_FAR) |->
            (m_red == CH_MAX) && (m_green == CH_MAX) && (m_blue == CH_MAX))
        else $error("far result is not white");

    a_range_sector: assert property (@(posedge aclk) disable iff (!aresetn)
        v3 && (ctl3.zone == ZONE_RANGE) |->
            (sector3 != 3'd6) && (sector3 != 3'd7))
        else $error("hue sector out of range");

    a_fill_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> v1 && v3 && m_valid && !m_ready)
        else $error("input stalled while the pipeline has room");
`endif

endmodule
